// ----- src/ltx_pkg.sv -----
`timescale 1ns / 1ps

package ltx_pkg;

    // Operating modes held in the configuration register.
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_MULTI  = 2'd2;
    localparam logic [1:0] MODE_TEX    = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_WIDE  = 2'd1;
    localparam logic [1:0] STAT_BREAK = 2'd2;

    // Pending escape codes; the fourth code is never stored and acts as none.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_BSL   = 2'd1;
    localparam logic [1:0] PEND_QUOTE = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CHAR_BSL     = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] LATIN1_FIRST = 8'hA0;

    // Transliteration lookup result: first character in the lowest byte.
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] chars;
    } ltx_xlit_t;

    // One classified input, handed from the front end to the output side.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      count;
        logic [1:0]      status;
        logic            emit;
    } ltx_desc_t;

    // Builds a lookup entry from a string literal of the given length.
    function automatic ltx_xlit_t mk(input logic [2:0] len, input logic [31:0] s);
        ltx_xlit_t r;
        int        k;
        r.len   = len;
        r.chars = '0;
        for (k = 0; k < 4; k++) begin
            if (k < int'(len)) begin
                r.chars[k] = s[8*(int'(len)-1-k) +: 8];
            end
        end
        return r;
    endfunction

    // Latin-1 upper half to ASCII; multi selects the multi-character table.
    function automatic ltx_xlit_t xlit(input logic [7:0] c, input logic multi);
        ltx_xlit_t r;
        r = mk(3'd0, 32'd0);
        case (c) inside
            8'hA0, 8'hB0: r = mk(3'd1, " ");
            8'hA1:        r = mk(3'd1, "!");
            8'hA2:        r = mk(3'd1, "c");
            8'hA5, 8'hDD: r = mk(3'd1, "Y");
            8'hA6:        r = mk(3'd1, "|");
            8'hA8:        r = mk(3'd1, "\"");
            8'hA9:        r = multi ? mk(3'd3, "(c)") : mk(3'd1, "c");
            8'hAA:        r = mk(3'd1, "a");
            8'hAB:        r = multi ? mk(3'd2, "<<") : mk(3'd1, "<");
            8'hAC, 8'hAD, 8'hAF: r = mk(3'd1, "-");
            8'hAE:        r = multi ? mk(3'd3, "(R)") : mk(3'd1, "R");
            8'hB1:        r = multi ? mk(3'd3, "+/-") : mk(3'd0, 32'd0);
            8'hB2:        r = mk(3'd1, "2");
            8'hB3:        r = mk(3'd1, "3");
            8'hB4:        r = mk(3'd1, "'");
            8'hB5:        r = mk(3'd1, "u");
            8'hB6:        r = mk(3'd1, "P");
            8'hB7:        r = mk(3'd1, ".");
            8'hB8:        r = mk(3'd1, ",");
            8'hB9:        r = mk(3'd1, "1");
            8'hBA:        r = mk(3'd1, "o");
            8'hBB:        r = multi ? mk(3'd2, ">>") : mk(3'd1, ">");
            8'hBC:        r = multi ? mk(3'd4, " 1/4") : mk(3'd0, 32'd0);
            8'hBD:        r = multi ? mk(3'd4, " 1/2") : mk(3'd0, 32'd0);
            8'hBE:        r = multi ? mk(3'd4, " 3/4") : mk(3'd0, 32'd0);
            8'hBF:        r = mk(3'd1, "?");
            [8'hC0:8'hC3]: r = mk(3'd1, "A");
            8'hC4:        r = multi ? mk(3'd2, "Ae") : mk(3'd1, "A");
            8'hC5:        r = multi ? mk(3'd2, "Aa") : mk(3'd1, "A");
            8'hC6:        r = multi ? mk(3'd2, "AE") : mk(3'd1, "A");
            8'hC7:        r = mk(3'd1, "C");
            [8'hC8:8'hCB]: r = mk(3'd1, "E");
            [8'hCC:8'hCF]: r = mk(3'd1, "I");
            8'hD0:        r = mk(3'd1, "D");
            8'hD1:        r = mk(3'd1, "N");
            [8'hD2:8'hD5]: r = mk(3'd1, "O");
            8'hD6, 8'hD8: r = multi ? mk(3'd2, "Oe") : mk(3'd1, "O");
            8'hD7:        r = mk(3'd1, "x");
            [8'hD9:8'hDB]: r = mk(3'd1, "U");
            8'hDC:        r = multi ? mk(3'd2, "Ue") : mk(3'd1, "U");
            8'hDE:        r = multi ? mk(3'd2, "Th") : mk(3'd1, "T");
            8'hDF:        r = multi ? mk(3'd2, "ss") : mk(3'd1, "s");
            [8'hE0:8'hE3]: r = mk(3'd1, "a");
            8'hE4, 8'hE6: r = multi ? mk(3'd2, "ae") : mk(3'd1, "a");
            8'hE5:        r = multi ? mk(3'd2, "aa") : mk(3'd1, "a");
            8'hE7:        r = mk(3'd1, "c");
            [8'hE8:8'hEB]: r = mk(3'd1, "e");
            [8'hEC:8'hEF]: r = mk(3'd1, "i");
            8'hF0:        r = mk(3'd1, "d");
            8'hF1:        r = mk(3'd1, "n");
            [8'hF2:8'hF5]: r = mk(3'd1, "o");
            8'hF6, 8'hF8: r = multi ? mk(3'd2, "oe") : mk(3'd1, "o");
            8'hF7:        r = mk(3'd1, ":");
            [8'hF9:8'hFB]: r = mk(3'd1, "u");
            8'hFC:        r = multi ? mk(3'd2, "ue") : mk(3'd1, "u");
            8'hFD:        r = mk(3'd1, "y");
            8'hFE:        r = multi ? mk(3'd2, "th") : mk(3'd1, "t");
            8'hFF:        r = multi ? mk(3'd2, "ij") : mk(3'd1, "y");
            default:      r = mk(3'd0, 32'd0);
        endcase
        return r;
    endfunction

    // Letter that follows a quote to form an umlaut; zero when there is none.
    function automatic logic [7:0] umlaut_of(input logic [7:0] c);
        logic [7:0] d;
        case (c) inside
            8'd34, 8'd39, 8'd96: d = 8'd34;
            8'd65:   d = 8'd196;
            8'd79:   d = 8'd214;
            8'd85:   d = 8'd220;
            8'd97:   d = 8'd228;
            8'd111:  d = 8'd246;
            8'd115:  d = 8'd223;
            8'd117:  d = 8'd252;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- src/ltx_front.sv -----
`timescale 1ns / 1ps

module ltx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              q_full,
    output logic              push,
    output ltx_pkg::ltx_desc_t desc
);

    logic [1:0]              mode_reg;
    logic [1:0]              pend_reg;
    logic [1:0]              pend_next;
    logic [7:0]              c;
    logic [7:0]              lim;
    logic                    en;
    logic [7:0]              uml;
    ltx_pkg::ltx_xlit_t      xl;

    assign c   = s_tdata[7:0];
    assign lim = s_tdata[15:8];
    assign en  = s_tdata[16];

    // A beat is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    assign xl  = ltx_pkg::xlit(c, mode_reg == ltx_pkg::MODE_MULTI);
    assign uml = (c >= 8'd32 && c <= 8'd127) ? ltx_pkg::umlaut_of(c) : 8'd0;

    // Classify the incoming byte into up to four characters and a status.
    always_comb begin
        desc        = '0;
        desc.emit   = en;
        desc.status = ltx_pkg::STAT_OK;
        pend_next   = pend_reg;
        unique case (mode_reg) inside
            ltx_pkg::MODE_SINGLE, ltx_pkg::MODE_MULTI: begin
                if (c < ltx_pkg::LATIN1_FIRST) begin
                    desc.chars[0] = c;
                    desc.count    = 3'd1;
                end else begin
                    desc.chars = xl.chars;
                    desc.count = xl.len;
                end
                if ({5'd0, desc.count} > lim) begin
                    desc.count  = 3'd0;
                    desc.status = ltx_pkg::STAT_WIDE;
                end
            end
            ltx_pkg::MODE_TEX: begin
                if (c == ltx_pkg::CHAR_BSL || c == ltx_pkg::CHAR_QUOTE) begin
                    // Held quote, or held BSL before BSL, is flushed.
                    if ((pend_reg == ltx_pkg::PEND_BSL && c == ltx_pkg::CHAR_BSL) ||
                        pend_reg == ltx_pkg::PEND_QUOTE) begin
                        desc.chars[0] = (pend_reg == ltx_pkg::PEND_BSL) ?
                                        ltx_pkg::CHAR_BSL : ltx_pkg::CHAR_QUOTE;
                        desc.count    = 3'd1;
                    end
                    pend_next = (c == ltx_pkg::CHAR_BSL) ? ltx_pkg::PEND_BSL
                                                          : ltx_pkg::PEND_QUOTE;
                end else if (pend_reg == ltx_pkg::PEND_BSL) begin
                    pend_next     = ltx_pkg::PEND_NONE;
                    desc.chars[0] = ltx_pkg::CHAR_BSL;
                    if (lim == 8'd1) begin
                        desc.count  = 3'd1;
                        desc.status = ltx_pkg::STAT_BREAK;
                    end else begin
                        desc.chars[1] = c;
                        desc.count    = 3'd2;
                    end
                end else if (pend_reg == ltx_pkg::PEND_QUOTE) begin
                    pend_next = ltx_pkg::PEND_NONE;
                    if (uml != 8'd0) begin
                        desc.chars[0] = uml;
                        desc.count    = 3'd1;
                    end else begin
                        desc.chars[0] = ltx_pkg::CHAR_QUOTE;
                        if (lim == 8'd1) begin
                            desc.count  = 3'd1;
                            desc.status = ltx_pkg::STAT_BREAK;
                        end else begin
                            desc.chars[1] = c;
                            desc.count    = 3'd2;
                        end
                    end
                end else begin
                    desc.chars[0] = c;
                    desc.count    = 3'd1;
                end
            end
            default: begin
                desc.chars[0] = c;
                desc.count    = 3'd1;
            end
        endcase
    end

    // Mode register and held escape.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ltx_pkg::MODE_PASS;
            pend_reg <= ltx_pkg::PEND_NONE;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (push) begin
                pend_reg <= pend_next;
            end
        end
    end

    // Only the TeX decoder may change the held escape.
    a_pend_tex_only: assert property (@(posedge aclk) disable iff (!aresetn)
        push && mode_reg != ltx_pkg::MODE_TEX |=> $stable(pend_reg))
        else $error("held escape changed outside TeX mode");

    // A line break always carries exactly the flushed escape character.
    a_break_single: assert property (@(posedge aclk) disable iff (!aresetn)
        push && desc.status == ltx_pkg::STAT_BREAK |->
        mode_reg == ltx_pkg::MODE_TEX && desc.count == 3'd1)
        else $error("line break outside TeX mode or with wrong count");

endmodule

// ----- src/ltx_queue.sv -----
`timescale 1ns / 1ps

module ltx_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ltx_pkg::ltx_desc_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output ltx_pkg::ltx_desc_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ltx_pkg::ltx_desc_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !valid))
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

endmodule

// ----- src/ltx_back.sv -----
`timescale 1ns / 1ps

module ltx_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ltx_pkg::ltx_desc_t q_head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    ltx_pkg::ltx_desc_t cur_reg, cur_next;
    logic [1:0]         idx_reg, idx_next;
    logic               busy_reg, busy_next;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    logic               m_tuser_reg;
    logic               m_tlast_reg;

    ltx_pkg::ltx_desc_t w;
    logic [1:0]         k;
    logic               have;
    logic               take;
    logic               empty;
    logic               is_last;
    logic [7:0]         ch;

    // Work from the held descriptor, or straight from the queue head.
    assign w       = busy_reg ? cur_reg : q_head;
    assign k       = busy_reg ? idx_reg : 2'd0;
    assign have    = busy_reg || q_valid;
    assign take    = have && (!m_tvalid_reg || m_tready);
    assign empty   = !w.emit || (w.count == 3'd0);
    assign is_last = empty || (({1'b0, k} + 3'd1) == w.count);
    assign ch      = empty ? 8'd0 : w.chars[k];
    assign pop     = take && !busy_reg;

    // Step through the characters of the current descriptor.
    always_comb begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (take) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else if (!busy_reg) begin
                busy_next = 1'b1;
                cur_next  = q_head;
                idx_next  = 2'd1;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (take) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output register and descriptor payload.
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        if (take) begin
            m_tdata_reg <= {3'd0, w.status, w.count, ch};
            m_tuser_reg <= !empty;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg |-> m_tlast_reg)
        else $error("empty beat not marked last");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, idx_reg} < cur_reg.count))
        else $error("character index beyond descriptor count");

endmodule

// ----- src/latin1_tex_char_substituter.sv -----
`timescale 1ns / 1ps

// Latin-1 / TeX character substituter.
// Input stream (s_*): one byte per beat with the columns still free on the
// line and an emit flag. Output stream (m_*): one character per beat, the
// last beat of each input marked with m_tlast; m_tuser is low on the single
// empty beat that carries only count and status.
// cfg_we/cfg_wdata write the mode: passthrough, single-width or
// multi-character transliteration of Latin-1, or TeX umlaut decoding.
// Write the mode only while the block holds no unfinished input.
// The first result beat of an input is registered in the descriptor queue and then in the output register.
// Throughput: the output side sends one beat per cycle while the receiver is
// ready, and an input has one to four result beats; the input side takes a
// beat per cycle while the descriptor queue between the classifier and the
// output sequencer has room.
// Reset clears the mode to passthrough, the held escape and the queue.
// When the receiver stalls, the output beat holds, the queue fills and then
// s_tready drops until space frees up.
module latin1_tex_char_substituter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_in[7:0], col_limit[15:8], emit_enable[16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_out[7:0], out_count[10:8], status[12:11]
    output logic        m_tuser,   // char_valid[0]
    output logic        m_tlast
);

    ltx_pkg::ltx_desc_t desc;
    ltx_pkg::ltx_desc_t q_head;
    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;

    ltx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .desc      (desc)
    );

    ltx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (desc),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ltx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
